@@ rtl/xrr_pkg.sv @@
// Package for the xorshift32 ranged random core.
// Holds word widths, the reset seed and the sequencer state type; no dependencies.
package xrr_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] SEED_RESET = 32'd2463534242;
  localparam logic [WORD_W-1:0] WORD_MAX   = {WORD_W{1'b1}};
  localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(WORD_W - 1);

  // xorshift32 shift amounts
  localparam int SH_A = 13;
  localparam int SH_B = 17;
  localparam int SH_C = 5;

  localparam logic CMD_RAW    = 1'b0;
  localparam logic CMD_RANGED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_DRAW,
    ST_REDUCE,
    ST_FINISH
  } xrr_state_t;

  function automatic logic [WORD_W-1:0] xs_advance(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] t;
    t = s ^ (s << SH_A);
    t = t ^ (t >> SH_B);
    t = t ^ (t << SH_C);
    return t;
  endfunction

endpackage

@@ rtl/xrr_in_if.sv @@
// Request channel of the xorshift32 ranged random core.
// Depends on xrr_pkg for the word width.
interface xrr_in_if;
  import xrr_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [WORD_W-1:0] range_min;
  logic [WORD_W-1:0] range_max;

  modport source (output valid, command, range_min, range_max, input ready);
  modport sink   (input valid, command, range_min, range_max, output ready);
endinterface

@@ rtl/xrr_out_if.sv @@
// Result channel of the xorshift32 ranged random core.
// Depends on xrr_pkg for the word width.
interface xrr_out_if;
  import xrr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

@@ rtl/xorshift32_ranged_random_core.sv @@
// xorshift32 generator with rejection-sampled ranged draws.
// Sequencing: a raw draw passes from idle through draw and finish; a ranged draw
// adds two 32-step passes of one serial divider and draws again for each rejected value.
// Throughput: one request at a time; the next request is taken once the sequencer
// is back in idle, while the previous result may still wait in the output register.
// Reset (rst_n, synchronous): generator state loads 2463534242, both channels idle.
module xorshift32_ranged_random_core
  import xrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  xrr_in_if.sink            in_chan,
  xrr_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata
);

  xrr_state_t        state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  logic [WORD_W-1:0] gen_r, gen_nxt;
  logic              ranged_r, ranged_nxt;
  logic [WORD_W-1:0] lo_r, lo_nxt;
  logic [WORD_W-1:0] range_r, range_nxt;
  logic [WORD_W-1:0] limit_r, limit_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              in_xfer;
  logic [WORD_W-1:0] req_range;
  logic [WORD_W-1:0] adv;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] rem_step;
  logic              fin_go;

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign in_xfer               = in_chan.valid && in_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.random_value = out_data_r;

  assign req_range = in_chan.range_max - in_chan.range_min + WORD_W'(1);
  assign adv       = xs_advance(gen_r);

  // One restoring-division step: remainder only, quotient dropped
  assign shifted  = {rem_r, dvd_r[WORD_W-1]};
  assign diff     = shifted - {1'b0, range_r};
  assign rem_step = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];

  assign fin_go = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    gen_nxt       = gen_r;
    ranged_nxt    = ranged_r;
    lo_nxt        = lo_r;
    range_nxt     = range_r;
    limit_nxt     = limit_r;
    res_nxt       = res_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          lo_nxt    = in_chan.range_min;
          range_nxt = req_range;
          // full span falls back to a raw draw
          if (in_chan.command == CMD_RANGED && req_range != '0) begin
            ranged_nxt = 1'b1;
            rem_nxt    = '0;
            dvd_nxt    = WORD_MAX;
            cnt_nxt    = '0;
            state_nxt  = ST_LIMIT;
          end else begin
            ranged_nxt = 1'b0;
            state_nxt  = ST_DRAW;
          end
        end
      end
      ST_LIMIT: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          limit_nxt = WORD_MAX - rem_step;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        gen_nxt = adv;
        if (!ranged_r) begin
          res_nxt   = adv;
          state_nxt = ST_FINISH;
        end else if (adv < limit_r) begin
          rem_nxt   = '0;
          dvd_nxt   = adv;
          cnt_nxt   = '0;
          state_nxt = ST_REDUCE;
        end
        // otherwise reject and draw again
      end
      ST_REDUCE: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          res_nxt   = lo_r + rem_step;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      gen_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gen_r       <= SEED_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      gen_r       <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    ranged_r   <= ranged_nxt;
    lo_r       <= lo_nxt;
    range_r    <= range_nxt;
    limit_r    <= limit_nxt;
    res_r      <= res_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    cnt_r      <= cnt_nxt;
  end

  // The divider remainder never reaches the divisor
  a_rem_below_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REDUCE || state_r == ST_LIMIT) |-> rem_r < range_r)
    else $error("divider remainder not below range");

  // A ranged draw's acceptance limit is a nonzero multiple of the range
  a_limit_ge_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW && ranged_r) |-> limit_r >= range_r)
    else $error("acceptance limit below range");

  // A raw request goes straight to one advance
  a_raw_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_chan.command == CMD_RAW) |=> (state_r == ST_DRAW && !ranged_r))
    else $error("raw request did not go to draw");

  // Leaving finish always presents a result
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && fin_go) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finish did not load output register");

endmodule
